// File: rtl/core/modexp_pkg.sv
`timescale 1ns / 1ps

package modexp_pkg;

    // field widths
    localparam int BASE_W    = 30;
    localparam int EXPO_W    = 32;
    localparam int RES_W     = 30;

    // number of exponent bits examined, low bits first
    localparam int EXP_WIDTH = 32;
    localparam int BIT_CNT_W = (EXP_WIDTH > 1) ? $clog2(EXP_WIDTH) : 1;

    // shared multiplier
    localparam int MUL_W     = 32;
    localparam int PROD_W    = 2 * MUL_W;

    // full modular product and barrett reduction, k = RES_W
    localparam int P_W       = 2 * RES_W;
    localparam int Q_SHIFT   = RES_W - 1;
    localparam int H_SHIFT   = RES_W + 1;
    localparam int Q_W       = P_W - Q_SHIFT;
    localparam int H_W       = 31;
    localparam int R_W       = 32;

    localparam logic [RES_W-1:0] MODULUS    = 30'd1000000007;
    // floor(2^60 / modulus)
    localparam logic [H_W-1:0]   BARRETT_MU = 31'd1152921496;

    // sequencer: seven steps per exponent bit
    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_MUL_ACC  = 8'b0000_0010,
        ST_MUL_SQ   = 8'b0000_0100,
        ST_EST_ACC  = 8'b0000_1000,
        ST_EST_SQ   = 8'b0001_0000,
        ST_BACK_ACC = 8'b0010_0000,
        ST_BACK_SQ  = 8'b0100_0000,
        ST_FOLD_SQ  = 8'b1000_0000
    } state_t;

endpackage

// File: rtl/core/modular_exponentiation_unit.sv
`timescale 1ns / 1ps

// Modular exponentiation: power_mod = base ** exponent mod 1000000007.
// Command channel: a transaction is taken at the rising edge where start is
// high and busy is low; base and exponent are sampled at that edge. A base at
// or above the modulus is reduced first. busy stays high while the item runs.
// Result channel: done is high for exactly one cycle with power_mod valid;
// the receiver has no way to stall, so it must take the value in that cycle.
// After the accepting edge the unit works through all 32 exponent bits, low
// bit first, and then raises done. busy falls in the same cycle done rises,
// so a new start may be taken at the edge ending that cycle; no new item is
// taken while one is running. Each exponent bit costs six passes through
// the single 32x32 registered multiplier (product, barrett estimate and
// back-multiply for both the accumulator and the running square) plus a
// correction step that folds the running square.
// An exponent of zero gives 1. Nothing is kept between items.
// Reset (rst_n low, asynchronous) returns the sequencer to idle and clears
// done; an item in flight is dropped.

module modular_exponentiation_unit
    import modexp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [BASE_W-1:0] base,
    input  logic [EXPO_W-1:0] exponent,
    output logic              done,
    output logic [RES_W-1:0]  power_mod
);

    state_t                 state_reg, state_next;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic                   done_reg, done_next;

    logic [RES_W-1:0]       acc_reg, acc_next;
    logic [RES_W-1:0]       sq_reg, sq_next;
    logic [EXP_WIDTH-1:0]   exp_reg, exp_next;
    logic [P_W-1:0]         p1_reg, p1_next;
    logic [P_W-1:0]         p2_reg, p2_next;
    logic [H_W-1:0]         h1_reg, h1_next;
    logic [H_W-1:0]         h2_reg, h2_next;
    logic [RES_W-1:0]       power_mod_reg, power_mod_next;

    logic [MUL_W-1:0]       mul_a, mul_b;
    logic [PROD_W-1:0]      mul_prod;
    logic                   accept;
    logic                   last_bit;
    logic [RES_W-1:0]       base_red;
    logic [RES_W-1:0]       fold_res;
    logic [R_W-1:0]         fold_lo;

    // barrett remainder lies below three moduli: pick r, r - m or r - 2m
    function automatic logic [RES_W-1:0] fold(input logic [R_W-1:0] r);
        logic [R_W-1:0] m1;
        logic [R_W-1:0] m2;
        logic [RES_W-1:0] res;
        m1 = R_W'(MODULUS);
        m2 = R_W'(MODULUS) << 1;
        if (r >= m2)
        begin
            res = RES_W'(r - m2);
        end
        else if (r >= m1)
        begin
            res = RES_W'(r - m1);
        end
        else
        begin
            res = RES_W'(r);
        end
        return res;
    endfunction

    // shared multiplier
    modexp_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_prod)
    );

    assign accept   = start && (state_reg == ST_IDLE);
    assign last_bit = (bit_cnt_reg == BIT_CNT_W'(EXP_WIDTH - 1));
    assign base_red = (base >= MODULUS) ? (base - MODULUS) : base;

    // low product word of the operand being folded this cycle
    assign fold_lo  = (state_reg == ST_FOLD_SQ) ? p2_reg[R_W-1:0] : p1_reg[R_W-1:0];
    assign fold_res = fold(fold_lo - mul_prod[R_W-1:0]);

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_MUL_ACC:
            begin
                mul_a = MUL_W'(acc_reg);
                mul_b = MUL_W'(sq_reg);
            end
            ST_MUL_SQ:
            begin
                mul_a = MUL_W'(sq_reg);
                mul_b = MUL_W'(sq_reg);
            end
            ST_EST_ACC:
            begin
                mul_a = MUL_W'(p1_reg[P_W-1:Q_SHIFT]);
                mul_b = MUL_W'(BARRETT_MU);
            end
            ST_EST_SQ:
            begin
                mul_a = MUL_W'(p2_reg[P_W-1:Q_SHIFT]);
                mul_b = MUL_W'(BARRETT_MU);
            end
            ST_BACK_ACC:
            begin
                mul_a = MUL_W'(h1_reg);
                mul_b = MUL_W'(MODULUS);
            end
            ST_BACK_SQ:
            begin
                mul_a = MUL_W'(h2_reg);
                mul_b = MUL_W'(MODULUS);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sequencer and datapath next state
    always_comb
    begin
        state_next     = state_reg;
        bit_cnt_next   = bit_cnt_reg;
        done_next      = 1'b0;
        acc_next       = acc_reg;
        sq_next        = sq_reg;
        exp_next       = exp_reg;
        p1_next        = p1_reg;
        p2_next        = p2_reg;
        h1_next        = h1_reg;
        h2_next        = h2_reg;
        power_mod_next = power_mod_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    sq_next      = base_red;
                    acc_next     = RES_W'(1);
                    exp_next     = EXP_WIDTH'(exponent);
                    bit_cnt_next = '0;
                    state_next   = ST_MUL_ACC;
                end
            end
            ST_MUL_ACC:
            begin
                state_next = ST_MUL_SQ;
            end
            ST_MUL_SQ:
            begin
                p1_next    = mul_prod[P_W-1:0];
                state_next = ST_EST_ACC;
            end
            ST_EST_ACC:
            begin
                p2_next    = mul_prod[P_W-1:0];
                state_next = ST_EST_SQ;
            end
            ST_EST_SQ:
            begin
                h1_next    = mul_prod[H_SHIFT +: H_W];
                state_next = ST_BACK_ACC;
            end
            ST_BACK_ACC:
            begin
                h2_next    = mul_prod[H_SHIFT +: H_W];
                state_next = ST_BACK_SQ;
            end
            ST_BACK_SQ:
            begin
                // accumulator takes the product only for a set exponent bit
                if (exp_reg[0])
                begin
                    acc_next = fold_res;
                end
                state_next = ST_FOLD_SQ;
            end
            ST_FOLD_SQ:
            begin
                sq_next  = fold_res;
                exp_next = exp_reg >> 1;
                if (last_bit)
                begin
                    power_mod_next = acc_reg;
                    done_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    bit_cnt_next = bit_cnt_reg + 1'b1;
                    state_next   = ST_MUL_ACC;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            bit_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
            done_reg    <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        acc_reg       <= acc_next;
        sq_reg        <= sq_next;
        exp_reg       <= exp_next;
        p1_reg        <= p1_next;
        p2_reg        <= p2_next;
        h1_reg        <= h1_next;
        h2_reg        <= h2_next;
        power_mod_reg <= power_mod_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign power_mod = power_mod_reg;

endmodule

// File: rtl/core/modexp_mul.sv
`timescale 1ns / 1ps

module modexp_mul
    import modexp_pkg::*;
(
    input  logic              clk,
    input  logic [MUL_W-1:0]  a,
    input  logic [MUL_W-1:0]  b,
    output logic [PROD_W-1:0] prod
);

    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;

    // unsigned product, registered
    always_comb
    begin
        prod_next = PROD_W'(a) * PROD_W'(b);
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// File: rtl/core/modexp_checker.sv
`timescale 1ns / 1ps

module modexp_checker
    import modexp_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             done,
    input logic [RES_W-1:0] power_mod
);

    // a result is always fully reduced
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (power_mod < MODULUS))
        else $error("power_mod not reduced below modulus");

    // an accepted transaction makes the unit busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // the unit is free again when its result appears
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while still busy");

    // busy ends only by delivering a result
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    // done never stays high, so a transaction gives no repeated result
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

endmodule

bind modular_exponentiation_unit modexp_checker u_modexp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .power_mod (power_mod)
);
